[rtl/double_adder_truncating_unit_defines.svh]
// Assertion macros for the double adder checker.
// Depends on nothing; included by the checker file only.
`ifndef DOUBLE_ADDER_TRUNCATING_UNIT_DEFINES_SVH
`define DOUBLE_ADDER_TRUNCATING_UNIT_DEFINES_SVH

// Implication checked on every clock, off during reset.
`define DAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dat assertion failed");

// Next-cycle implication.
`define DAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dat assertion failed");

`endif

[rtl/dat_pkg.sv]
// Shared types and constants for the truncating double adder.
// Depends on nothing; imported by every module of the block.
package dat_pkg;

    localparam int FracW  = 52;
    localparam int ExpW   = 11;
    localparam int MaxShift = 53;
    localparam int SigW   = 54;           // hidden one, fraction, one carry bit
    localparam int PosW   = 6;
    localparam int PipeDepth = 4;

    typedef struct packed {
        logic        kind;
        logic [63:0] a_bits;
        logic [63:0] b_bits;
    } dat_in_t;

    typedef struct packed {
        logic [63:0] sum_bits;
        logic        exp_wrapped;
    } dat_out_t;

    // Stage 1 -> 2: sorted operands and bypass decision
    typedef struct packed {
        logic             bypass;
        logic [63:0]      bypass_bits;
        logic             sl;
        logic             st;
        logic [ExpW-1:0]  el;
        logic [5:0]       shift_amt;
        logic [FracW:0]   ml;
        logic [FracW:0]   mt;
    } dat_s1_t;

    // Stage 2 -> 3: signed magnitude of the sum
    typedef struct packed {
        logic             bypass;
        logic [63:0]      bypass_bits;
        logic             sign;
        logic [ExpW-1:0]  el;
        logic [SigW-1:0]  mag;
    } dat_s2_t;

    // Leading one position of a 54-bit value
    function automatic logic [PosW-1:0] lead_pos(input logic [SigW-1:0] v);
        logic [PosW-1:0] p;
        p = '0;
        for (int i = 0; i < SigW; i++)
        begin
            if (v[i])
            begin
                p = PosW'(i);
            end
        end
        return p;
    endfunction

endpackage

[rtl/dat_align.sv]
// Stage 1: sign flip, zero and far-apart checks, operand sort.
// Depends on dat_pkg.
module dat_align
    import dat_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  dat_in_t in_beat,
    output logic    out_valid,
    output dat_s1_t out_beat
);

    logic          valid_reg;
    dat_s1_t       beat_reg;
    dat_s1_t       beat_next;

    // Decode and sort
    always_comb
    begin
        logic [63:0]     a;
        logic [63:0]     b;
        logic [63:0]     lead;
        logic [63:0]     trail;
        logic [ExpW-1:0] ea;
        logic [ExpW-1:0] eb;
        logic [ExpW-1:0] d;
        a = in_beat.a_bits;
        b = in_beat.b_bits ^ {in_beat.kind, 63'd0};
        ea = a[62:52];
        eb = b[62:52];
        if (ea < eb)
        begin
            lead = b;
            trail = a;
        end
        else
        begin
            lead = a;
            trail = b;
        end
        d = lead[62:52] - trail[62:52];
        beat_next.sl = lead[63];
        beat_next.st = trail[63];
        beat_next.el = lead[62:52];
        beat_next.shift_amt = d[5:0];
        beat_next.ml = {1'b1, lead[FracW-1:0]};
        beat_next.mt = {1'b1, trail[FracW-1:0]};
        beat_next.bypass = 1'b1;
        if (ea == '0)
        begin
            beat_next.bypass_bits = b;
        end
        else if (eb == '0)
        begin
            beat_next.bypass_bits = a;
        end
        else if (d > ExpW'(MaxShift))
        begin
            beat_next.bypass_bits = lead;
        end
        else
        begin
            beat_next.bypass = 1'b0;
            beat_next.bypass_bits = lead;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

[rtl/dat_addsub.sv]
// Stage 2: shift trailing significand, two's-complement add, magnitude.
// Depends on dat_pkg.
module dat_addsub
    import dat_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  dat_s1_t in_beat,
    output logic    out_valid,
    output dat_s2_t out_beat
);

    logic    valid_reg;
    dat_s2_t beat_reg;
    dat_s2_t beat_next;

    // Aligned add; both terms fit in 55 signed bits
    always_comb
    begin
        logic [SigW:0] ml;
        logic [SigW:0] mt;
        logic [SigW:0] s;
        ml = {2'b00, in_beat.ml};
        mt = {2'b00, in_beat.mt} >> in_beat.shift_amt;
        if (in_beat.sl)
        begin
            ml = -ml;
        end
        if (in_beat.st)
        begin
            mt = -mt;
        end
        s = ml + mt;
        beat_next.sign = s[SigW];
        if (s[SigW])
        begin
            s = -s;
        end
        beat_next.mag = s[SigW-1:0];
        beat_next.el = in_beat.el;
        beat_next.bypass = in_beat.bypass;
        beat_next.bypass_bits = in_beat.bypass_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

[rtl/dat_norm.sv]
// Stages 3 and 4: leading-one search, then shift, exponent and packing.
// Depends on dat_pkg.
module dat_norm
    import dat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  dat_s2_t  in_beat,
    output logic     out_valid,
    output dat_out_t out_beat
);

    logic            valid3_reg;
    dat_s2_t         beat3_reg;
    logic [PosW-1:0] pos_reg;
    logic            valid4_reg;
    dat_out_t        res_reg;
    dat_out_t        res_next;

    // Leading one search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid3_reg <= in_valid;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        beat3_reg <= in_beat;
        pos_reg   <= lead_pos(in_beat.mag);
        res_reg   <= res_next;
    end

    // Normalize, truncate, pack; leading one lands at the top bit of sh
    always_comb
    begin
        logic [SigW-1:0] sh;
        logic [ExpW+1:0] e;
        sh = beat3_reg.mag << (PosW'(SigW - 1) - pos_reg);
        e = {2'b00, beat3_reg.el} + {{(ExpW-PosW+2){1'b0}}, pos_reg};
        res_next.sum_bits = {beat3_reg.sign, ExpW'(e - 13'd52), sh[SigW-2:1]};
        res_next.exp_wrapped = (e < 13'd53) || (e > 13'd2099);
        if (beat3_reg.bypass)
        begin
            res_next.sum_bits = beat3_reg.bypass_bits;
            res_next.exp_wrapped = 1'b0;
        end
        else if (beat3_reg.mag == '0)
        begin
            res_next.sum_bits = '0;
            res_next.exp_wrapped = 1'b0;
        end
    end

    assign out_valid = valid4_reg;
    assign out_beat  = res_reg;

endmodule

[rtl/double_adder_truncating_unit.sv]
// Top level of the truncating double adder: four-stage pipeline.
// Depends on dat_pkg, dat_align, dat_addsub, dat_norm.
//
// Adds or subtracts two IEEE double bit patterns with truncation. A beat is
// taken on every cycle that start is high (busy is always low); its result
// appears on res with done high, one cycle wide, in order, after passing the
// four register stages: sort, add, leading-one search, normalize. The
// receiver cannot stall the results.
module double_adder_truncating_unit
    import dat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dat_in_t  operands,
    output logic     done,
    output dat_out_t res
);

    logic    v1;
    logic    v2;
    dat_s1_t b1;
    dat_s2_t b2;

    dat_align u_align (.clk(clk), .rst_n(rst_n), .in_valid(start), .in_beat(operands),
                       .out_valid(v1), .out_beat(b1));
    dat_addsub u_add (.clk(clk), .rst_n(rst_n), .in_valid(v1), .in_beat(b1),
                      .out_valid(v2), .out_beat(b2));
    dat_norm u_norm (.clk(clk), .rst_n(rst_n), .in_valid(v2), .in_beat(b2),
                     .out_valid(done), .out_beat(res));

    // Full-rate pipeline never pushes back
    assign busy = 1'b0;

endmodule

[rtl/dat_checker.sv]
// Port-level checker for the truncating double adder, bound to the top.
// Depends on dat_pkg and double_adder_truncating_unit_defines.svh.
`include "double_adder_truncating_unit_defines.svh"

module dat_port_props
    import dat_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input dat_in_t  operands,
    input logic     done,
    input dat_out_t res
);

    `DAT_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
    `DAT_ASSERT_IMP(a_done_follows, clk, rst_n, done, $past(start, 4))
    `DAT_ASSERT_IMP(a_start_gives_done, clk, rst_n, $past(start, 4) && $past(rst_n, 4), done)
    `DAT_ASSERT_IMP(a_result_known, clk, rst_n, done, !$isunknown(res))

endmodule

bind double_adder_truncating_unit dat_port_props u_dat_port_props (.*);

[tb/dat_checker.sv]
// Checker for the truncating double adder: predicts each sum and compares.
// Depends on dat_pkg; watches the command and result channels of the block.
module dat_checker
    import dat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  dat_in_t  operands,
    input  logic     done,
    input  dat_out_t res,
    output int       fail_count,
    output int       pending_sums,
    output int       sums_seen
);

    localparam logic KIND_SUB = 1'b1;

    dat_out_t expected_sums[$];

    function automatic logic [10:0] exp_field(input logic [63:0] x);
        return x[62:52];
    endfunction

    // Truncating add/subtract of two double bit patterns
    function automatic dat_out_t predict_sum(input dat_in_t op);
        dat_out_t r;
        logic [63:0] a, b, lead, trail, ml, mt, total, word;
        logic [10:0] el, et;
        int shift_amt, pos, true_exp;
        a = op.a_bits;
        b = op.b_bits;
        r = '0;
        if (op.kind == KIND_SUB)
        begin
            b[63] = ~b[63];
        end
        if (exp_field(a) == 0)
        begin
            r.sum_bits = b;
            return r;
        end
        if (exp_field(b) == 0)
        begin
            r.sum_bits = a;
            return r;
        end
        if (exp_field(a) < exp_field(b))
        begin
            lead = b;
            trail = a;
        end
        else
        begin
            lead = a;
            trail = b;
        end
        el = exp_field(lead);
        et = exp_field(trail);
        shift_amt = int'(el) - int'(et);
        if (shift_amt > MaxShift)
        begin
            r.sum_bits = lead;
            return r;
        end
        ml = {12'd1, lead[51:0]};
        mt = {12'd1, trail[51:0]} >> shift_amt;
        if (lead[63])
        begin
            ml = -ml;
        end
        if (trail[63])
        begin
            mt = -mt;
        end
        total = ml + mt;
        word = '0;
        if (total[63])
        begin
            total = -total;
            word[63] = 1'b1;
        end
        if (total == 0)
        begin
            return r;
        end
        pos = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (total[i])
            begin
                pos = i;
            end
        end
        if (pos >= 52)
        begin
            word[51:0] = 52'(total >> (pos - 52));
        end
        else
        begin
            word[51:0] = 52'(total << (52 - pos));
        end
        true_exp = int'(el) + pos - 52;
        word[62:52] = true_exp[10:0];
        r.sum_bits = word;
        r.exp_wrapped = (true_exp < 1) || (true_exp > 2047);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_sums = expected_sums.size();

    // Queue a prediction per accepted beat; compare each result beat
    always @(posedge clk or negedge rst_n)
    begin
        dat_out_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            sums_seen = 0;
            expected_sums.delete();
        end
        else
        begin
            if (done)
            begin
                sums_seen++;
                if (expected_sums.size() == 0)
                begin
                    report_mismatch("unexpected result", res.sum_bits, '0);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (res.sum_bits !== want.sum_bits)
                    begin
                        report_mismatch("sum_bits", res.sum_bits, want.sum_bits);
                    end
                    if (res.exp_wrapped !== want.exp_wrapped)
                    begin
                        report_mismatch("exp_wrapped", 64'(res.exp_wrapped),
                                        64'(want.exp_wrapped));
                    end
                end
            end
            if (start && !busy)
            begin
                expected_sums.push_back(predict_sum(operands));
            end
        end
    end

endmodule

[tb/tb_double_adder_truncating_unit.sv]
// Testbench top for the truncating double adder: stimulus and verdict.
// Depends on dat_pkg, dat_checker and the block itself.
module tb_double_adder_truncating_unit;
    import dat_pkg::*;

    localparam int NumRandom = 1630;
    localparam int CycleLimit = 400000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    dat_in_t  operands;
    logic     done;
    dat_out_t res;
    int       fail_count;
    int       pending_sums;
    int       sums_seen;
    int       cycle_count = 0;
    int       beats_sent;

    double_adder_truncating_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .res      (res)
    );

    dat_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operands     (operands),
        .done         (done),
        .res          (res),
        .fail_count   (fail_count),
        .pending_sums (pending_sums),
        .sums_seen    (sums_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("tb_double_adder_truncating_unit: errors");
            $finish;
        end
    end

    function automatic logic [63:0] make_double(input logic s, input logic [10:0] e,
                                                input logic [51:0] f);
        return {s, e, f};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random operand pair, mostly close exponents so the add path is busy
    function automatic dat_in_t random_pair();
        dat_in_t p;
        int mode;
        logic [10:0] ea, eb;
        p.kind = 1'($urandom_range(0, 1));
        p.a_bits = rand64();
        p.b_bits = rand64();
        mode = $urandom_range(0, 9);
        ea = p.a_bits[62:52];
        if (mode < 5)
        begin
            eb = ea + 11'($urandom_range(0, 6)) - 11'd3;
            p.b_bits[62:52] = eb;
        end
        else if (mode < 6)
        begin
            // near-cancellation
            p.b_bits = p.a_bits ^ 64'($urandom_range(0, 15));
            p.b_bits[63] = p.a_bits[63] ^ ~p.kind;
        end
        else if (mode < 7)
        begin
            p.b_bits[62:52] = ea + 11'($urandom_range(50, 56));
        end
        else if (mode < 8)
        begin
            if ($urandom_range(0, 1))
            begin
                p.a_bits[62:52] = 11'd0;
            end
            else
            begin
                p.b_bits[62:52] = 11'd0;
            end
        end
        else if (mode < 9)
        begin
            p.a_bits[62:52] = $urandom_range(0, 1) ? 11'd2047 : 11'd1;
            p.b_bits[62:52] = p.a_bits[62:52] - 11'($urandom_range(0, 2));
        end
        return p;
    endfunction

    // Present one beat, then idle for a random gap
    task automatic send_beat(input dat_in_t p);
        int gap;
        start <= 1'b1;
        operands <= p;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        beats_sent++;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic dat_in_t pair(input logic k, input logic [63:0] a,
                                     input logic [63:0] b);
        dat_in_t p;
        p.kind = k;
        p.a_bits = a;
        p.b_bits = b;
        return p;
    endfunction

    initial
    begin
        int drain;
        beats_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operands = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, far apart, cancellation, wrap, extremes
        send_beat(pair(1'b0, 64'd0, 64'd0));
        send_beat(pair(1'b1, 64'd0, 64'd0));
        send_beat(pair(1'b0, 64'd0, make_double(1'b1, 11'd1023, 52'h12345)));
        send_beat(pair(1'b1, make_double(1'b0, 11'd1000, 52'hABC), 64'd0));
        send_beat(pair(1'b0, make_double(1'b0, 11'd1100, '0),
                       make_double(1'b0, 11'd1046, '1)));
        send_beat(pair(1'b0, make_double(1'b1, 11'd1100, '0),
                       make_double(1'b0, 11'd1047, '1)));
        send_beat(pair(1'b1, make_double(1'b0, 11'd1023, 52'h5),
                       make_double(1'b0, 11'd1023, 52'h5)));
        send_beat(pair(1'b0, make_double(1'b0, 11'd1023, '1),
                       make_double(1'b1, 11'd1023, '1)));
        send_beat(pair(1'b0, make_double(1'b0, 11'd2047, '1),
                       make_double(1'b0, 11'd2047, '1)));
        send_beat(pair(1'b1, make_double(1'b1, 11'd2047, '0),
                       make_double(1'b0, 11'd2046, '1)));
        send_beat(pair(1'b1, make_double(1'b0, 11'd1, '0), make_double(1'b0, 11'd1, 52'h1)));
        send_beat(pair(1'b0, make_double(1'b0, 11'd1, '1), make_double(1'b1, 11'd2, '0)));
        send_beat(pair(1'b0, make_double(1'b0, 11'd1023, '0),
                       make_double(1'b0, 11'd1023, '0)));
        send_beat(pair(1'b1, make_double(1'b1, 11'd500, '1),
                       make_double(1'b0, 11'd447, '1)));
        send_beat(pair(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_beat(pair(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF));
        send_beat(pair(1'b0, make_double(1'b0, 11'd1023, '0),
                       make_double(1'b1, 11'd1022, '1)));
        send_beat(pair(1'b0, make_double(1'b1, 11'd1023, '0),
                       make_double(1'b1, 11'd1023, '0)));

        for (int i = 0; i < NumRandom; i++)
        begin
            send_beat(random_pair());
        end
        start <= 1'b0;

        // Drain the pipeline
        drain = 0;
        while (pending_sums != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (2 * PipeDepth + 4) @(posedge clk);

        $display("covered %0d beats, %0d results checked (zero, far-apart, cancel, wrap)",
                 beats_sent, sums_seen);
        if (fail_count == 0 && pending_sums == 0)
        begin
            $display("tb_double_adder_truncating_unit: clean");
        end
        else
        begin
            $display("tb_double_adder_truncating_unit: errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/dat_pkg.sv
rtl/dat_align.sv
rtl/dat_addsub.sv
rtl/dat_norm.sv
rtl/double_adder_truncating_unit.sv
rtl/dat_checker.sv
tb/dat_checker.sv
tb/tb_double_adder_truncating_unit.sv
